// ===== src/nsr_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence receiver package
// Shared constants, types and helpers for the sentence parser, the command
// queue and the payload emitter.
// ----------------------------------------------------------------------------
package nsr_pkg;

   localparam int MAX_PAYLOAD = 64;
   localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
   localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
   localparam int RAM_AW      = ADDR_W + 1;

   localparam logic [7:0] START_CHAR    = 8'h24;
   localparam logic [7:0] CHECKSUM_CHAR = 8'h2A;
   localparam logic [7:0] DIGIT_BASE    = 8'h30;
   localparam logic [7:0] LETTER_BASE   = 8'h37;
   localparam logic [3:0] DIGIT_LIMIT   = 4'd10;

   typedef enum logic [1:0] {
      MODE_WAIT,
      MODE_PAYLOAD,
      MODE_CHECK1,
      MODE_CHECK2
   } parse_mode_type;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_READ,
      EMIT_SHOW
   } emit_state_type;

   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
   } sentence_cmd_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } bank_release_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      logic [7:0] wide;
      wide = {4'b0000, nibble};
      if (nibble < DIGIT_LIMIT) begin
         return DIGIT_BASE + wide;
      end
      return LETTER_BASE + wide;
   endfunction

endpackage

// ===== src/nsr_ram.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence receiver payload RAM
// Simple dual-port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nsr_ram #(
   parameter int WIDTH = 8,
   parameter int AW    = 7
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [2**AW];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/nsr_parser.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence parser
// Accepts received bytes, stores the payload into the free RAM bank, tracks
// the XOR checksum and queues a command for each sentence that checks good.
// ----------------------------------------------------------------------------
module nsr_parser
   import nsr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_rx_byte,
   output logic                    wr_en,
   output logic [RAM_AW-1:0]       wr_addr,
   output logic [7:0]              wr_data,
   output logic                    cmd_push,
   output sentence_cmd_type        cmd_data,
   input  bank_release_type        release_bank
);

   parse_mode_type   mode_ff, mode_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       check1_ff, check1_in;
   logic             bank_ff, bank_in;
   logic [1:0]       busy_ff, busy_in;

   logic accept;
   logic is_start;
   logic is_checksum;
   logic is_full;
   logic sum_ok;
   logic start;
   logic store;
   logic capture;
   logic commit;

   assign req_stall   = busy_ff[bank_ff];
   assign accept      = req_valid && !req_stall;
   assign is_start    = req_rx_byte == START_CHAR;
   assign is_checksum = req_rx_byte == CHECKSUM_CHAR;
   assign is_full     = count_ff == CNT_W'(MAX_PAYLOAD);
   assign sum_ok      = (check1_ff == hex_char(xor_ff[7:4]))
                     && (req_rx_byte == hex_char(xor_ff[3:0]));

   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         case (mode_ff)
            MODE_WAIT: begin
               if (is_start) begin
                  mode_in = MODE_PAYLOAD;
               end
            end
            MODE_PAYLOAD: begin
               if (is_checksum) begin
                  mode_in = MODE_CHECK1;
               end else if (is_full) begin
                  mode_in = MODE_WAIT;
               end
            end
            MODE_CHECK1: mode_in = MODE_CHECK2;
            MODE_CHECK2: mode_in = MODE_WAIT;
            default:     mode_in = MODE_WAIT;
         endcase
      end
   end

   always_comb begin
      start   = accept && (mode_ff == MODE_WAIT) && is_start;
      store   = accept && (mode_ff == MODE_PAYLOAD) && !is_checksum && !is_full;
      capture = accept && (mode_ff == MODE_CHECK1);
      commit  = accept && (mode_ff == MODE_CHECK2) && sum_ok;

      count_in  = count_ff;
      xor_in    = xor_ff;
      check1_in = capture ? req_rx_byte : check1_ff;
      bank_in   = commit ? !bank_ff : bank_ff;
      busy_in   = busy_ff;

      if (start) begin
         count_in = '0;
         xor_in   = '0;
      end else if (store) begin
         count_in = count_ff + CNT_W'(1);
         xor_in   = xor_ff ^ req_rx_byte;
      end
      if (release_bank.valid) begin
         busy_in[release_bank.bank] = 1'b0;
      end
      if (commit) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_WAIT;
         count_ff  <= '0;
         xor_ff    <= '0;
         check1_ff <= '0;
         bank_ff   <= 1'b0;
         busy_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         xor_ff    <= xor_in;
         check1_ff <= check1_in;
         bank_ff   <= bank_in;
         busy_ff   <= busy_in;
      end
   end

   assign wr_en          = store;
   assign wr_addr        = {bank_ff, count_ff[ADDR_W-1:0]};
   assign wr_data        = req_rx_byte;
   assign cmd_push       = commit;
   assign cmd_data.bank  = bank_ff;
   assign cmd_data.count = count_ff;

endmodule

// ===== src/nsr_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence command queue
// Two-entry queue of checked sentences between the parser and the emitter.
// ----------------------------------------------------------------------------
module nsr_cmd_fifo
   import nsr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sentence_cmd_type push_data,
   input  logic             pop,
   output logic             head_valid,
   output sentence_cmd_type head_data
);

   sentence_cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       level_ff, level_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 2'd1;
      end else if (pop && !push) begin
         level_in = level_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = level_ff != 2'd0;
   assign head_data  = q_ff[rd_ptr_ff];

endmodule

// ===== src/nsr_emitter.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence emitter
// Pops checked sentences, walks their payload bank and sends one beat per
// byte, or a single marker beat for an empty sentence.
// ----------------------------------------------------------------------------
module nsr_emitter
   import nsr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  sentence_cmd_type    cmd_data,
   output logic                cmd_pop,
   output logic                rd_en,
   output logic [RAM_AW-1:0]   rd_addr,
   input  logic [7:0]          rd_data,
   output bank_release_type    release_bank,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_sentence_byte,
   output logic                rsp_byte_present,
   output logic                rsp_last_byte
);

   emit_state_type   state_ff, state_in;
   logic             bank_ff, bank_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             present_ff, present_in;
   logic             last_ff, last_in;
   logic             beat_done;

   assign beat_done = (state_ff == EMIT_SHOW) && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EMIT_IDLE: begin
            if (cmd_valid) begin
               state_in = (cmd_data.count == '0) ? EMIT_SHOW : EMIT_READ;
            end
         end
         EMIT_READ: state_in = EMIT_SHOW;
         EMIT_SHOW: begin
            if (!rsp_stall) begin
               state_in = last_ff ? EMIT_IDLE : EMIT_READ;
            end
         end
         default: state_in = EMIT_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop            = (state_ff == EMIT_IDLE) && cmd_valid;
      rd_en              = state_ff == EMIT_READ;
      rd_addr            = {bank_ff, idx_ff[ADDR_W-1:0]};
      release_bank.valid = beat_done && last_ff;
      release_bank.bank  = bank_ff;
      rsp_valid          = state_ff == EMIT_SHOW;

      bank_in    = bank_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      present_in = present_ff;
      last_in    = last_ff;
      if (cmd_pop) begin
         bank_in    = cmd_data.bank;
         cnt_in     = cmd_data.count;
         idx_in     = '0;
         present_in = cmd_data.count != '0;
         last_in    = cmd_data.count == '0;
      end else if (rd_en) begin
         present_in = 1'b1;
         last_in    = (idx_ff + CNT_W'(1)) == cnt_ff;
      end else if (beat_done) begin
         idx_in = idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EMIT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff    <= bank_in;
      cnt_ff     <= cnt_in;
      idx_ff     <= idx_in;
      present_ff <= present_in;
      last_ff    <= last_in;
   end

   assign rsp_sentence_byte = present_ff ? rd_data : 8'h00;
   assign rsp_byte_present  = present_ff;
   assign rsp_last_byte     = last_ff;

endmodule

// ===== src/nmea_sentence_receiver.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence receiver
// Checks the XOR checksum of NMEA 0183 sentences and forwards good payloads.
// ----------------------------------------------------------------------------
// A received byte is taken whenever req_stall is low. Payload bytes after
// '$' go into one of two 64-byte RAM banks; a sentence whose two uppercase
// hex checksum characters match is queued for output, a bad or overlong one
// is dropped without output. The emitter picks up each queued sentence and
// for each payload byte does one RAM read and shows one beat on the rsp
// channel, held while rsp_stall is high; an empty sentence gives a single
// beat with rsp_byte_present low. The input stalls only when both banks
// hold sentences still waiting to leave.
// No clearing pass is needed after reset.
module nmea_sentence_receiver
   import nsr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_sentence_byte,
   output logic       rsp_byte_present,
   output logic       rsp_last_byte
);

   logic              wr_en;
   logic [RAM_AW-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [RAM_AW-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              cmd_push;
   sentence_cmd_type  cmd_push_data;
   logic              cmd_pop;
   logic              cmd_valid;
   sentence_cmd_type  cmd_head;
   bank_release_type  release_bank;

   nsr_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .cmd_push     (cmd_push),
      .cmd_data     (cmd_push_data),
      .release_bank (release_bank)
   );

   nsr_ram #(
      .WIDTH (8),
      .AW    (RAM_AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nsr_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_push_data),
      .pop        (cmd_pop),
      .head_valid (cmd_valid),
      .head_data  (cmd_head)
   );

   nsr_emitter u_emitter (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd_data          (cmd_head),
      .cmd_pop           (cmd_pop),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .release_bank      (release_bank),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sentence_byte (rsp_sentence_byte),
      .rsp_byte_present  (rsp_byte_present),
      .rsp_last_byte     (rsp_last_byte)
   );

endmodule

// ===== src/nsr_checker.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence receiver checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module nsr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_sentence_byte,
   input logic       rsp_byte_present,
   input logic       rsp_last_byte
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_present |-> rsp_last_byte)
      else $error("empty marker beat without last mark");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_present |-> rsp_sentence_byte == 8'h00)
      else $error("empty marker beat carries a nonzero byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sentence_byte)
         && $stable(rsp_byte_present) && $stable(rsp_last_byte))
      else $error("stalled result beat changed");

endmodule

bind nmea_sentence_receiver nsr_checker u_nsr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_sentence_byte (rsp_sentence_byte),
   .rsp_byte_present  (rsp_byte_present),
   .rsp_last_byte     (rsp_last_byte)
);

// ===== bench/tb_nmea_sentence_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence receiver testbench
// Feeds received characters into the block and checks every payload beat
// against a cycle-free model of the sentence parser. The model follows the
// start character, payload store, running XOR and the two uppercase hex
// checksum characters. Directed tests cover noise while waiting, empty,
// full and overlong payloads, bad and lowercase checksums, and a start
// character inside the payload. A random run of mostly well-formed
// sentences follows. Both channels idle at random, except during one
// back-to-back stretch.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_receiver;
   import nsr_pkg::*;

   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          RANDOM_CHARS = 24;
   localparam int          DRAIN_CYCLES = 2 * MAX_PAYLOAD + 8;
   localparam logic [127:0] HEX_UPPER   = "0123456789ABCDEF";

   typedef enum logic [1:0] {
      SUM_GOOD,
      SUM_BAD,
      SUM_LOWER,
      SUM_RANDOM
   } sum_kind_type;

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       is_last;
   } payload_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_sentence_byte;
   logic       rsp_byte_present;
   logic       rsp_last_byte;

   logic sender_idles = 1'b1;
   logic receiver_idles = 1'b1;

   int cycle_count = 0;
   int fail_count = 0;
   int chars_sent = 0;
   int sentences_sent = 0;
   int beats_checked = 0;

   payload_beat_type awaited_beats[$];
   logic [7:0]       sentence_body[$];

   parse_mode_type   rx_mode = MODE_WAIT;
   logic [7:0]       rx_store [MAX_PAYLOAD];
   logic [CNT_W-1:0] rx_count = '0;
   logic [7:0]       rx_xor = 8'h00;
   logic [7:0]       rx_first = 8'h00;

   nmea_sentence_receiver DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sentence_byte (rsp_sentence_byte),
      .rsp_byte_present  (rsp_byte_present),
      .rsp_last_byte     (rsp_last_byte)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] hex_upper(input logic [3:0] nibble);
      return HEX_UPPER[8 * (15 - nibble) +: 8];
   endfunction

   // Parse one accepted character and queue the payload beats it releases.
   task automatic parse_rx_char(input logic [7:0] c);
      payload_beat_type beat;
      int i;
      case (rx_mode)
         MODE_WAIT: begin
            if (c == START_CHAR) begin
               rx_count = '0;
               rx_xor = 8'h00;
               rx_mode = MODE_PAYLOAD;
            end
         end
         MODE_PAYLOAD: begin
            if (c == CHECKSUM_CHAR) begin
               rx_mode = MODE_CHECK1;
            end else if (rx_count >= CNT_W'(MAX_PAYLOAD)) begin
               rx_count = '0;
               rx_xor = 8'h00;
               rx_mode = MODE_WAIT;
            end else begin
               rx_store[rx_count[ADDR_W-1:0]] = c;
               rx_count = rx_count + CNT_W'(1);
               rx_xor = rx_xor ^ c;
            end
         end
         MODE_CHECK1: begin
            rx_first = c;
            rx_mode = MODE_CHECK2;
         end
         default: begin
            if (rx_first == hex_upper(rx_xor[7:4]) && c == hex_upper(rx_xor[3:0])) begin
               if (rx_count == '0) begin
                  beat.data = 8'h00;
                  beat.present = 1'b0;
                  beat.is_last = 1'b1;
                  awaited_beats.push_back(beat);
               end else begin
                  for (i = 0; i < int'(rx_count); i++) begin
                     beat.data = rx_store[i];
                     beat.present = 1'b1;
                     beat.is_last = (i + 1 == int'(rx_count));
                     awaited_beats.push_back(beat);
                  end
               end
            end
            rx_count = '0;
            rx_xor = 8'h00;
            rx_mode = MODE_WAIT;
         end
      endcase
   endtask

   task automatic check_beat();
      payload_beat_type want;
      if (awaited_beats.size() == 0) begin
         $error("unexpected beat: byte %h present %b last %b",
                rsp_sentence_byte, rsp_byte_present, rsp_last_byte);
         fail_count++;
      end else begin
         want = awaited_beats.pop_front();
         beats_checked++;
         if (rsp_sentence_byte !== want.data) begin
            $error("rsp_sentence_byte: expected %h, got %h", want.data, rsp_sentence_byte);
            fail_count++;
         end
         if (rsp_byte_present !== want.present) begin
            $error("rsp_byte_present: expected %b, got %b", want.present, rsp_byte_present);
            fail_count++;
         end
         if (rsp_last_byte !== want.is_last) begin
            $error("rsp_last_byte: expected %b, got %b", want.is_last, rsp_last_byte);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         check_beat();
      end
      rsp_stall <= receiver_idles && ($urandom_range(99) < 15);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // Hold valid until the beat is taken; gaps only ever lower it.
   task automatic send_char(input logic [7:0] c);
      while (sender_idles && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= c;
      do @(posedge clock); while (req_stall);
      parse_rx_char(c);
      chars_sent++;
   endtask

   task automatic fill_body(input int len, input logic allow_start);
      logic [7:0] c;
      int i;
      sentence_body.delete();
      for (i = 0; i < len; i++) begin
         c = 8'($urandom_range(255));
         if (c == CHECKSUM_CHAR || (!allow_start && c == START_CHAR)) begin
            c = c ^ 8'h40;
         end
         sentence_body.push_back(c);
      end
   endtask

   task automatic send_sentence(input sum_kind_type kind, input logic full = 1'b1);
      logic [7:0] sum;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [3:0] skew;
      int i;
      sum = 8'h00;
      for (i = 0; i < sentence_body.size(); i++) begin
         sum = sum ^ sentence_body[i];
      end
      hi = hex_upper(sum[7:4]);
      lo = hex_upper(sum[3:0]);
      case (kind)
         SUM_BAD: begin
            skew = 4'($urandom_range(1, 15));
            if ($urandom_range(1)) begin
               hi = hex_upper(sum[7:4] ^ skew);
            end else begin
               lo = hex_upper(sum[3:0] ^ skew);
            end
         end
         SUM_LOWER: begin
            hi = hi | 8'h20;
            lo = lo | 8'h20;
         end
         SUM_RANDOM: begin
            hi = 8'($urandom_range(255));
            lo = 8'($urandom_range(255));
         end
         default: ;
      endcase
      send_char(START_CHAR);
      for (i = 0; i < sentence_body.size(); i++) begin
         send_char(sentence_body[i]);
      end
      send_char(CHECKSUM_CHAR);
      send_char(hi);
      if (full) begin
         send_char(lo);
      end
      sentences_sent++;
   endtask

   // Drop valid, then hold until every awaited beat has been checked.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (awaited_beats.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_idle_noise();
      send_char(8'h00);
      send_char(8'hFF);
      send_char(CHECKSUM_CHAR);
      send_char("A");
   endtask

   task automatic test_empty_sentence();
      sentence_body.delete();
      send_sentence(SUM_GOOD);
   endtask

   task automatic test_checksum_cases();
      sentence_body = '{8'h00, 8'hFF, START_CHAR, "G", "P"};
      send_sentence(SUM_GOOD);
      sentence_body = '{"Z"};
      send_sentence(SUM_LOWER);
      sentence_body = '{"G", "N"};
      send_sentence(SUM_BAD);
      sentence_body = '{8'h55};
      send_sentence(SUM_RANDOM);
   endtask

   task automatic test_full_payload();
      fill_body(MAX_PAYLOAD, 1'b1);
      send_sentence(SUM_GOOD);
   endtask

   task automatic test_overflow();
      fill_body(MAX_PAYLOAD + 1, 1'b0);
      send_sentence(SUM_GOOD);
      sentence_body = '{"O", "K"};
      send_sentence(SUM_GOOD);
   endtask

   task automatic test_drain_then_send();
      fill_body(2, 1'b1);
      send_sentence(SUM_GOOD);
      wait_for_drain();
      fill_body(1, 1'b1);
      send_sentence(SUM_GOOD);
   endtask

   task automatic test_back_to_back();
      int i;
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      for (i = 0; i < 4; i++) begin
         fill_body(5, 1'b1);
         send_sentence(SUM_GOOD);
      end
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
   endtask

   task automatic test_random_traffic();
      int start_count;
      int pick;
      int len;
      int noise;
      start_count = chars_sent;
      while (chars_sent - start_count < RANDOM_CHARS) begin
         pick = $urandom_range(99);
         len = $urandom_range(0, 10);
         fill_body(len, 1'b1);
         if (pick < 70) begin
            send_sentence(SUM_GOOD);
         end else if (pick < 78) begin
            send_sentence(SUM_BAD);
         end else if (pick < 84) begin
            send_sentence(SUM_LOWER);
         end else if (pick < 90) begin
            send_sentence(SUM_RANDOM);
         end else if (pick < 95) begin
            send_sentence(SUM_GOOD, 1'b0);
         end else begin
            noise = $urandom_range(1, 4);
            repeat (noise) send_char(8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_noise();
      test_empty_sentence();
      test_checksum_cases();
      test_full_payload();
      test_overflow();
      test_drain_then_send();
      test_back_to_back();
      test_random_traffic();
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_beats.size() != 0) begin
         $error("%0d payload beats never arrived", awaited_beats.size());
         fail_count++;
      end
      $display("Sent %0d characters in %0d sentences; checked %0d payload beats.",
               chars_sent, sentences_sent, beats_checked);
      $display("Covered noise, empty, full, overlong, bad and lowercase checksum sentences.");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
